FILE: rtl/shm_pkg.sv
// ---------------------------------------------------------------------------
// shm_pkg - shared definitions for the sensor health monitor
// Types, field layouts, register indexes and controller/datapath interface.
// ---------------------------------------------------------------------------
package shm_pkg;

    localparam int SENSORS = 5;
    localparam int IDX_W   = (SENSORS > 1) ? $clog2(SENSORS) : 1;

    localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;
    localparam logic [7:0]  RUN_MAX    = 8'hFF;

    // configuration reset values
    localparam logic [7:0]  FAULT_TH_RST  = 8'd3;
    localparam logic [7:0]  RECOV_TH_RST  = 8'd3;
    localparam logic [31:0] SHORT_FRESH_RST = 32'd300;
    localparam logic [31:0] LONG_FRESH_RST  = 32'd1000;

    // request data layout, lowest bit first
    localparam int IN_SENSOR_LO = 0;
    localparam int IN_NOW_LO    = 3;
    localparam int IN_BUS_LO    = 35;
    localparam int IN_PV_LO     = 37;
    localparam int IN_SV_LO     = 69;
    localparam int IN_DATA_W    = 88;

    // report data layout, lowest bit first
    localparam int OUT_ID_LO     = 0;
    localparam int OUT_HEALTH_LO = 3;
    localparam int OUT_AGE_LO    = 6;
    localparam int OUT_MAIN_LO   = 38;
    localparam int OUT_AUX_LO    = 70;
    localparam int OUT_GOOD_LO   = 86;
    localparam int OUT_BAD_LO    = 118;
    localparam int OUT_STAT_LO   = 150;
    localparam int OUT_DATA_W    = 152;

    typedef enum logic [2:0] {
        H_STARTING   = 3'd0,
        H_HEALTHY    = 3'd1,
        H_DEGRADED   = 3'd2,
        H_FAULTED    = 3'd3,
        H_RECOVERING = 3'd4
    } t_health;

    typedef enum logic [1:0] {
        CFG_FAULT_TH    = 2'd0,
        CFG_RECOV_TH    = 2'd1,
        CFG_SHORT_FRESH = 2'd2,
        CFG_LONG_FRESH  = 2'd3
    } t_cfg_idx;

    localparam logic [1:0] BUS_OK = 2'd0;

    typedef struct packed {
        logic             capture;
        logic             do_read;
        logic             do_refresh;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic is_refresh;
        logic sensor_ok;
        logic slot_free;
    } t_stat;

endpackage

FILE: rtl/shm_ctrl.sv
// ---------------------------------------------------------------------------
// shm_ctrl - sequencer of the sensor health monitor
// Accepts one request at a time, then either applies a read result or walks
// every sensor record, one report per step.
// ---------------------------------------------------------------------------
module shm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  shm_pkg::t_stat i_stat,
    output shm_pkg::t_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                    r_state, n_state;
    logic [shm_pkg::IDX_W-1:0] r_walk, n_walk;
    logic                      accept;
    logic                      walk_end;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign walk_end   = (r_walk == shm_pkg::IDX_W'(shm_pkg::SENSORS - 1));

    always_comb begin
        n_state          = r_state;
        n_walk           = r_walk;
        o_cmd.capture    = accept;
        o_cmd.do_read    = 1'b0;
        o_cmd.do_refresh = 1'b0;
        o_cmd.idx        = r_walk;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RUN;
                    n_walk  = '0;
                end
            end
            S_RUN: begin
                if (!i_stat.is_refresh) begin
                    o_cmd.do_read = i_stat.sensor_ok;
                    n_state       = S_IDLE;
                end else if (i_stat.slot_free) begin
                    // one report per step, held back while the output is full
                    o_cmd.do_refresh = 1'b1;
                    if (walk_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_walk = r_walk + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_walk  <= '0;
        end else begin
            r_state <= n_state;
            r_walk  <= n_walk;
        end
    end

endmodule

FILE: rtl/shm_dp.sv
// ---------------------------------------------------------------------------
// shm_dp - datapath of the sensor health monitor
// Configuration registers, per-sensor records, update logic for read results
// and refresh steps, and the report output register.
// ---------------------------------------------------------------------------
module shm_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write
    input  logic                             i_cfg_valid,
    input  logic [1:0]                       i_cfg_index,
    input  logic [31:0]                      i_cfg_data,
    // request payload
    input  logic [shm_pkg::IN_DATA_W-1:0]    i_s_tdata,
    input  logic                             i_s_tuser,
    // report side
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    output logic [shm_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output logic                             o_m_tlast,
    // controller link
    input  shm_pkg::t_cmd                    i_cmd,
    output shm_pkg::t_stat                   o_stat
);

    localparam int S = shm_pkg::SENSORS;
    localparam int W = shm_pkg::IDX_W;

    // configuration
    logic [7:0]  r_fault_th;
    logic [7:0]  r_recov_th;
    logic [31:0] r_short_fresh;
    logic [31:0] r_long_fresh;

    // captured request
    logic        r_kind;
    logic [2:0]  r_sensor;
    logic [31:0] r_now;
    logic [1:0]  r_bus;
    logic [31:0] r_pv;
    logic [15:0] r_sv;

    // per-sensor records
    shm_pkg::t_health r_health [S];
    logic [7:0]       r_fail_run [S];
    logic [7:0]       r_ok_run [S];
    logic [31:0]      r_good [S];
    logic [31:0]      r_bad [S];
    logic [31:0]      r_stamp [S];
    logic [31:0]      r_main [S];
    logic [15:0]      r_aux [S];
    logic [1:0]       r_recent [S];
    logic [31:0]      r_age [S];

    // report register
    logic                            r_m_valid;
    logic [shm_pkg::OUT_DATA_W-1:0]  r_m_data;
    logic                            r_m_last;

    logic [W-1:0]     sel;
    logic             is_last_sensor;
    logic [7:0]       cur_fail, cur_ok;
    logic [31:0]      cur_good, cur_bad, cur_stamp;
    logic [7:0]       ok_inc, fail_inc;
    logic [31:0]      good_inc, bad_inc;
    shm_pkg::t_health rd_health;
    logic [31:0]      limit;
    logic [31:0]      age_calc;
    shm_pkg::t_health rf_health;
    logic [31:0]      rf_age;

    assign sel            = r_kind ? i_cmd.idx : W'(r_sensor);
    assign is_last_sensor = (sel == W'(S - 1));

    assign cur_fail  = r_fail_run[sel];
    assign cur_ok    = r_ok_run[sel];
    assign cur_good  = r_good[sel];
    assign cur_bad   = r_bad[sel];
    assign cur_stamp = r_stamp[sel];

    assign ok_inc   = (cur_ok == shm_pkg::RUN_MAX) ? cur_ok : cur_ok + 8'd1;
    assign fail_inc = (cur_fail == shm_pkg::RUN_MAX) ? cur_fail : cur_fail + 8'd1;
    assign good_inc = (cur_good == shm_pkg::ALL_ONES32) ? cur_good : cur_good + 32'd1;
    assign bad_inc  = (cur_bad == shm_pkg::ALL_ONES32) ? cur_bad : cur_bad + 32'd1;

    // read result outcome
    always_comb begin
        if (r_bus == shm_pkg::BUS_OK) begin
            rd_health = (ok_inc >= r_recov_th) ? shm_pkg::H_HEALTHY
                                               : shm_pkg::H_RECOVERING;
        end else if (fail_inc >= r_fault_th) begin
            rd_health = shm_pkg::H_FAULTED;
        end else if (cur_good != 32'd0) begin
            rd_health = shm_pkg::H_DEGRADED;
        end else begin
            rd_health = shm_pkg::H_STARTING;
        end
    end

    // refresh step outcome
    assign limit    = is_last_sensor ? r_long_fresh : r_short_fresh;
    assign age_calc = (r_now >= cur_stamp) ? r_now - cur_stamp : 32'd0;

    always_comb begin
        rf_health = r_health[sel];
        rf_age    = age_calc;
        if (cur_good == 32'd0) begin
            rf_health = shm_pkg::H_STARTING;
            rf_age    = shm_pkg::ALL_ONES32;
        end else if ((age_calc >= limit) && (cur_fail >= r_fault_th)) begin
            rf_health = shm_pkg::H_FAULTED;
        end
    end

    assign o_stat.is_refresh = r_kind;
    assign o_stat.sensor_ok  = (32'(r_sensor) < 32'(S));
    assign o_stat.slot_free  = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault_th    <= shm_pkg::FAULT_TH_RST;
            r_recov_th    <= shm_pkg::RECOV_TH_RST;
            r_short_fresh <= shm_pkg::SHORT_FRESH_RST;
            r_long_fresh  <= shm_pkg::LONG_FRESH_RST;
            r_m_valid     <= 1'b0;
            for (int i = 0; i < S; i++) begin
                r_health[i]   <= shm_pkg::H_STARTING;
                r_fail_run[i] <= '0;
                r_ok_run[i]   <= '0;
                r_good[i]     <= '0;
                r_bad[i]      <= '0;
                r_stamp[i]    <= '0;
                r_main[i]     <= '0;
                r_aux[i]      <= '0;
                r_recent[i]   <= '0;
                r_age[i]      <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (shm_pkg::t_cfg_idx'(i_cfg_index))
                    shm_pkg::CFG_FAULT_TH:    r_fault_th    <= i_cfg_data[7:0];
                    shm_pkg::CFG_RECOV_TH:    r_recov_th    <= i_cfg_data[7:0];
                    shm_pkg::CFG_SHORT_FRESH: r_short_fresh <= i_cfg_data;
                    shm_pkg::CFG_LONG_FRESH:  r_long_fresh  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.do_read) begin
                r_recent[sel] <= r_bus;
                r_health[sel] <= rd_health;
                if (r_bus == shm_pkg::BUS_OK) begin
                    r_main[sel]     <= r_pv;
                    r_aux[sel]      <= r_sv;
                    r_stamp[sel]    <= r_now;
                    r_good[sel]     <= good_inc;
                    r_fail_run[sel] <= '0;
                    r_ok_run[sel]   <= ok_inc;
                end else begin
                    r_bad[sel]      <= bad_inc;
                    r_fail_run[sel] <= fail_inc;
                    r_ok_run[sel]   <= '0;
                end
            end

            if (i_cmd.do_refresh) begin
                r_health[sel] <= rf_health;
                r_age[sel]    <= rf_age;
                r_m_valid     <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_s_tuser;
            r_sensor <= i_s_tdata[shm_pkg::IN_SENSOR_LO +: 3];
            r_now    <= i_s_tdata[shm_pkg::IN_NOW_LO +: 32];
            r_bus    <= i_s_tdata[shm_pkg::IN_BUS_LO +: 2];
            r_pv     <= i_s_tdata[shm_pkg::IN_PV_LO +: 32];
            r_sv     <= i_s_tdata[shm_pkg::IN_SV_LO +: 16];
        end
        if (i_cmd.do_refresh) begin
            r_m_last <= is_last_sensor;
            r_m_data <= {r_recent[sel], cur_bad, cur_good, r_aux[sel], r_main[sel],
                         rf_age, rf_health, 3'(sel)};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;

endmodule

FILE: rtl/sensor_health_monitor_top.sv
// ---------------------------------------------------------------------------
// sensor_health_monitor_top - per-sensor health records with refresh reports
//
//   channel  direction  handshake              payload
//   s        in         i_s_tvalid/o_s_tready  i_s_tdata, i_s_tuser (kind)
//   m        out        o_m_tvalid/i_m_tready  o_m_tdata, o_m_tlast
//   cfg      in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// a read result is captured, then its record is updated
// a refresh is captured, then walks one record per cycle,
// each step waiting until the single report register is free
// one request is in flight at a time; a stalled report holds the walk
// synchronous active-low reset restores all records and register defaults
// ---------------------------------------------------------------------------
module sensor_health_monitor_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request: sensor, now_ms, bus_status, primary_value, secondary_value, pad
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [shm_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  logic                            i_s_tuser,   // kind
    // report: sensor_id, health, age_ms, value_main, value_aux, good_total,
    // bad_total, recent_status
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [shm_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic                            o_m_tlast,
    // configuration write
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [1:0]                      i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);

    shm_pkg::t_cmd  cmd;
    shm_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    shm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    shm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

    // one request at a time: busy right after a request is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while previous one still in progress");

    // an intermediate report means the walk is still running
    a_walk_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> !o_s_tready)
        else $error("input open while a refresh walk is unfinished");

    // the closing report belongs to the last sensor
    a_last_sensor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |->
            (o_m_tdata[shm_pkg::OUT_ID_LO +: 3] == 3'(shm_pkg::SENSORS - 1)))
        else $error("tlast on a report that is not for the last sensor");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench for sensor_health_monitor_top
// Feeds read results and refresh requests under several threshold and
// freshness settings, predicts every refresh report from a software copy of
// the per-sensor records, and compares the reports field by field.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic       KIND_READ    = 1'b0;
    localparam logic       KIND_REFRESH = 1'b1;
    localparam logic [1:0] BUS_NACK     = 2'd1;
    localparam logic [1:0] BUS_SHORT    = 2'd2;
    localparam logic [1:0] BUS_UNKNOWN  = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [2:0]  sensor;
        logic [31:0] now;
        logic [1:0]  bus;
        logic [31:0] pv;
        logic [15:0] sv;
    } t_sensor_req;

    typedef struct packed {
        logic [2:0]       sensor_id;
        shm_pkg::t_health health;
        logic [31:0]      age_ms;
        logic [31:0]      value_main;
        logic [15:0]      value_aux;
        logic [31:0]      good_total;
        logic [31:0]      bad_total;
        logic [1:0]       recent_status;
        logic             last;
    } t_health_report;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_s_tvalid  = 1'b0;
    logic                           o_s_tready;
    logic [shm_pkg::IN_DATA_W-1:0]  i_s_tdata   = '0;
    logic                           i_s_tuser   = 1'b0;
    logic                           o_m_tvalid;
    logic                           i_m_tready  = 1'b0;
    logic [shm_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic                           o_m_tlast;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [1:0]                     i_cfg_index = shm_pkg::CFG_FAULT_TH;
    logic [31:0]                    i_cfg_data  = '0;

    sensor_health_monitor_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // predicted copy of the records and registers
    logic [7:0]  th_fault    = shm_pkg::FAULT_TH_RST;
    logic [7:0]  th_recov    = shm_pkg::RECOV_TH_RST;
    logic [31:0] fresh_short = shm_pkg::SHORT_FRESH_RST;
    logic [31:0] fresh_long  = shm_pkg::LONG_FRESH_RST;

    shm_pkg::t_health rec_health   [shm_pkg::SENSORS];
    logic [7:0]       rec_fail_run [shm_pkg::SENSORS];
    logic [7:0]       rec_ok_run   [shm_pkg::SENSORS];
    logic [31:0]      rec_good     [shm_pkg::SENSORS];
    logic [31:0]      rec_bad      [shm_pkg::SENSORS];
    logic [31:0]      rec_stamp    [shm_pkg::SENSORS];
    logic [31:0]      rec_main     [shm_pkg::SENSORS];
    logic [15:0]      rec_aux      [shm_pkg::SENSORS];
    logic [1:0]       rec_status   [shm_pkg::SENSORS];
    logic [31:0]      rec_age      [shm_pkg::SENSORS];

    t_sensor_req    pending_reqs [$];
    t_health_report expected_reports [$];
    t_sensor_req    cur_req;
    int             mismatches = 0;
    int             src_idle   = 9;
    int             snk_idle   = 85;
    int             stall_left = 0;
    logic           stall_arm  = 1'b0;
    logic           stall_used = 1'b0;
    logic [31:0]    ms_now     = '0;

    function automatic t_sensor_req mk_read(input logic [2:0] sensor, input logic [31:0] now,
                                            input logic [1:0] bus, input logic [31:0] pv,
                                            input logic [15:0] sv);
        t_sensor_req r;
        r.kind   = KIND_READ;
        r.sensor = sensor;
        r.now    = now;
        r.bus    = bus;
        r.pv     = pv;
        r.sv     = sv;
        return r;
    endfunction

    // sensor, status and values ride along unused on a refresh
    function automatic t_sensor_req mk_refresh(input logic [31:0] now);
        t_sensor_req r;
        r.kind   = KIND_REFRESH;
        r.sensor = 3'($urandom_range(7));
        r.now    = now;
        r.bus    = 2'($urandom_range(3));
        r.pv     = $urandom();
        r.sv     = 16'($urandom());
        return r;
    endfunction

    function automatic void update_records(input t_sensor_req rq);
        logic [31:0]    limit;
        logic [31:0]    age;
        t_health_report rep;
        int             n;
        if (rq.kind == KIND_READ) begin
            if (int'(rq.sensor) >= shm_pkg::SENSORS)
                return;
            n = int'(rq.sensor);
            rec_status[n] = rq.bus;
            if (rq.bus == shm_pkg::BUS_OK) begin
                rec_main[n]  = rq.pv;
                rec_aux[n]   = rq.sv;
                rec_stamp[n] = rq.now;
                if (rec_good[n] != shm_pkg::ALL_ONES32)
                    rec_good[n]++;
                rec_fail_run[n] = '0;
                if (rec_ok_run[n] != shm_pkg::RUN_MAX)
                    rec_ok_run[n]++;
                rec_health[n] = (rec_ok_run[n] >= th_recov) ? shm_pkg::H_HEALTHY
                                                            : shm_pkg::H_RECOVERING;
            end else begin
                if (rec_bad[n] != shm_pkg::ALL_ONES32)
                    rec_bad[n]++;
                if (rec_fail_run[n] != shm_pkg::RUN_MAX)
                    rec_fail_run[n]++;
                rec_ok_run[n] = '0;
                if (rec_fail_run[n] >= th_fault)
                    rec_health[n] = shm_pkg::H_FAULTED;
                else if (rec_good[n] != 32'd0)
                    rec_health[n] = shm_pkg::H_DEGRADED;
                else
                    rec_health[n] = shm_pkg::H_STARTING;
            end
            return;
        end
        for (n = 0; n < shm_pkg::SENSORS; n++) begin
            limit = (n == shm_pkg::SENSORS - 1) ? fresh_long : fresh_short;
            if (rec_good[n] == 32'd0) begin
                rec_health[n] = shm_pkg::H_STARTING;
                rec_age[n]    = shm_pkg::ALL_ONES32;
            end else begin
                // a clock that went backwards counts as fresh
                age = (rq.now >= rec_stamp[n]) ? rq.now - rec_stamp[n] : 32'd0;
                rec_age[n] = age;
                if (age >= limit && rec_fail_run[n] >= th_fault)
                    rec_health[n] = shm_pkg::H_FAULTED;
            end
            rep.sensor_id     = 3'(n);
            rep.health        = rec_health[n];
            rep.age_ms        = rec_age[n];
            rep.value_main    = rec_main[n];
            rep.value_aux     = rec_aux[n];
            rep.good_total    = rec_good[n];
            rep.bad_total     = rec_bad[n];
            rep.recent_status = rec_status[n];
            rep.last          = (n == shm_pkg::SENSORS - 1);
            expected_reports.push_back(rep);
        end
    endfunction

    function automatic void check_report();
        t_health_report got;
        t_health_report want;
        got.sensor_id     = o_m_tdata[shm_pkg::OUT_ID_LO +: 3];
        got.health        = shm_pkg::t_health'(o_m_tdata[shm_pkg::OUT_HEALTH_LO +: 3]);
        got.age_ms        = o_m_tdata[shm_pkg::OUT_AGE_LO +: 32];
        got.value_main    = o_m_tdata[shm_pkg::OUT_MAIN_LO +: 32];
        got.value_aux     = o_m_tdata[shm_pkg::OUT_AUX_LO +: 16];
        got.good_total    = o_m_tdata[shm_pkg::OUT_GOOD_LO +: 32];
        got.bad_total     = o_m_tdata[shm_pkg::OUT_BAD_LO +: 32];
        got.recent_status = o_m_tdata[shm_pkg::OUT_STAT_LO +: 2];
        got.last          = o_m_tlast;
        if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected report for sensor %0d", $realtime, got.sensor_id);
            return;
        end
        want = expected_reports.pop_front();
        if (got.sensor_id !== want.sensor_id || got.health !== want.health ||
            got.age_ms !== want.age_ms || got.value_main !== want.value_main ||
            got.value_aux !== want.value_aux || got.good_total !== want.good_total ||
            got.bad_total !== want.bad_total || got.recent_status !== want.recent_status ||
            got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: report mismatch", $realtime);
                $display("  expected id %0d health %0d age %h main %h aux %h",
                         want.sensor_id, want.health, want.age_ms, want.value_main,
                         want.value_aux);
                $display("           good %0d bad %0d st %0d last %0d",
                         want.good_total, want.bad_total, want.recent_status, want.last);
                $display("  actual   id %0d health %0d age %h main %h aux %h",
                         got.sensor_id, got.health, got.age_ms, got.value_main,
                         got.value_aux);
                $display("           good %0d bad %0d st %0d last %0d",
                         got.good_total, got.bad_total, got.recent_status, got.last);
            end
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
            i_s_tuser  <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                update_records(cur_req);
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle) begin
                    cur_req = pending_reqs.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {3'b000, cur_req.sv, cur_req.pv, cur_req.bus,
                                   cur_req.now, cur_req.sensor};
                    i_s_tuser  <= cur_req.kind;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // report monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready)
                check_report();
            i_m_tready <= (stall_left == 0) && ($urandom_range(99) >= snk_idle);
        end
    end

    // one long back-pressure stretch, so the block backs up onto its input
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (stall_arm && !stall_used) begin
            stall_left <= 400;
            stall_used <= 1'b1;
        end
    end

    task automatic wait_quiet();
        while (pending_reqs.size() != 0 || i_s_tvalid || expected_reports.size() != 0)
            @(posedge i_clk);
        // a trailing read result still updates its record without a report
        repeat (8) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [7:0] fault, input logic [7:0] recov,
                                input logic [31:0] short_ms, input logic [31:0] long_ms);
        shm_pkg::t_cfg_idx order [4] = '{shm_pkg::CFG_FAULT_TH, shm_pkg::CFG_RECOV_TH,
                                         shm_pkg::CFG_SHORT_FRESH, shm_pkg::CFG_LONG_FRESH};
        logic [31:0]       vals  [4];
        vals = '{{24'd0, fault}, {24'd0, recov}, short_ms, long_ms};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= order[k];
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (order[k])
                shm_pkg::CFG_FAULT_TH:    th_fault    = vals[k][7:0];
                shm_pkg::CFG_RECOV_TH:    th_recov    = vals[k][7:0];
                shm_pkg::CFG_SHORT_FRESH: fresh_short = vals[k];
                shm_pkg::CFG_LONG_FRESH:  fresh_long  = vals[k];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // bursts of reads on one sensor with mostly the same outcome, plus refreshes
    task automatic queue_random(input int count);
        int         made;
        int         len;
        int         pick;
        logic [2:0] sensor;
        logic [1:0] bus;
        bit         good;
        made = 0;
        while (made < count) begin
            pick = int'($urandom_range(99));
            if (pick < 20) begin
                if ($urandom_range(7) == 0)
                    pending_reqs.push_back(mk_refresh(ms_now - $urandom_range(500)));
                else
                    pending_reqs.push_back(mk_refresh(ms_now + $urandom_range(1500)));
                made++;
            end else if (pick < 26) begin
                // indexes past the last sensor are dropped by the block
                pending_reqs.push_back(mk_read(3'($urandom_range(7, shm_pkg::SENSORS)),
                                               ms_now, 2'($urandom_range(3)), $urandom(),
                                               16'($urandom())));
            end else begin
                sensor = 3'($urandom_range(shm_pkg::SENSORS - 1));
                len    = int'($urandom_range(1, 5));
                good   = 1'($urandom_range(1));
                repeat (len) begin
                    if (good && $urandom_range(9) != 0)
                        bus = shm_pkg::BUS_OK;
                    else
                        bus = 2'($urandom_range(BUS_NACK, BUS_UNKNOWN));
                    ms_now += $urandom_range(120);
                    pending_reqs.push_back(mk_read(sensor, ms_now, bus, $urandom(),
                                                   16'($urandom())));
                    made++;
                end
            end
        end
    endtask

    initial begin
        for (int n = 0; n < shm_pkg::SENSORS; n++) begin
            rec_health[n]   = shm_pkg::H_STARTING;
            rec_fail_run[n] = '0;
            rec_ok_run[n]   = '0;
            rec_good[n]     = '0;
            rec_bad[n]      = '0;
            rec_stamp[n]    = '0;
            rec_main[n]     = '0;
            rec_aux[n]      = '0;
            rec_status[n]   = '0;
            rec_age[n]      = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: unsampled refresh, recovery, faults without a good sample,
        // dropped indexes, limit reached exactly, time going backwards, extremes
        pending_reqs.push_back(mk_refresh(32'd0));
        pending_reqs.push_back(mk_read(3'd0, 32'd100, shm_pkg::BUS_OK,
                                       shm_pkg::ALL_ONES32, 16'hFFFF));
        pending_reqs.push_back(mk_read(3'd0, 32'd110, shm_pkg::BUS_OK, 32'h1234_5678, 16'h00FF));
        pending_reqs.push_back(mk_read(3'd0, 32'd120, shm_pkg::BUS_OK, 32'd0, 16'd0));
        pending_reqs.push_back(mk_read(3'd1, 32'd130, BUS_NACK, 32'd7, 16'd7));
        pending_reqs.push_back(mk_read(3'd1, 32'd131, BUS_SHORT, 32'd8, 16'd8));
        pending_reqs.push_back(mk_read(3'd1, 32'd132, BUS_UNKNOWN, 32'd9, 16'd9));
        pending_reqs.push_back(mk_read(3'd2, 32'd140, shm_pkg::BUS_OK, 32'hDEAD_BEEF, 16'h8001));
        pending_reqs.push_back(mk_read(3'd2, 32'd150, BUS_NACK, 32'd1, 16'd1));
        pending_reqs.push_back(mk_read(3'd4, 32'd160, shm_pkg::BUS_OK, 32'hA5A5_A5A5, 16'h5A5A));
        pending_reqs.push_back(mk_read(3'd5, 32'd170, shm_pkg::BUS_OK, 32'h5555_5555, 16'h1111));
        pending_reqs.push_back(mk_read(3'd7, 32'd170, BUS_NACK, 32'hAAAA_AAAA, 16'h2222));
        pending_reqs.push_back(mk_read(3'd3, 32'd180, BUS_NACK, 32'd0, 16'd0));
        pending_reqs.push_back(mk_refresh(32'd420));
        pending_reqs.push_back(mk_refresh(32'd50));
        pending_reqs.push_back(mk_read(3'd3, 32'd500, BUS_NACK, 32'd0, 16'd0));
        pending_reqs.push_back(mk_read(3'd3, 32'd501, BUS_SHORT, 32'd0, 16'd0));
        pending_reqs.push_back(mk_read(3'd2, 32'd510, BUS_UNKNOWN, 32'd0, 16'd0));
        pending_reqs.push_back(mk_read(3'd2, 32'd520, BUS_NACK, 32'd0, 16'd0));
        pending_reqs.push_back(mk_refresh(shm_pkg::ALL_ONES32));
        pending_reqs.push_back(mk_read(3'd2, 32'd600, shm_pkg::BUS_OK, 32'h0F0F_0F0F, 16'hF0F0));
        pending_reqs.push_back(mk_read(3'd0, 32'd700, BUS_NACK, 32'd0, 16'd0));
        pending_reqs.push_back(mk_refresh(shm_pkg::ALL_ONES32));
        wait_quiet();

        // single-step thresholds; lowered fault threshold catches stale degraded sensors
        program_regs(8'd1, 8'd1, 32'd0, shm_pkg::ALL_ONES32);
        ms_now = 32'h0000_1000;
        pending_reqs.push_back(mk_refresh(ms_now));
        queue_random(44);
        wait_quiet();

        src_idle <= 85;
        snk_idle <= 9;
        program_regs(8'd0, 8'd0, 32'd50, 32'd200);
        ms_now = $urandom();
        queue_random(44);
        wait_quiet();

        src_idle <= 0;
        snk_idle <= 0;
        program_regs(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                     $urandom_range(20, 400), $urandom_range(100, 1500));
        ms_now = $urandom();
        queue_random(44);
        stall_arm <= 1'b1;
        wait_quiet();

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
